// ===== design/pts_pkg.sv =====
// Shared types, widths and codes for the playback time sequencer.
`default_nettype none

package pts_pkg;

    // Width of a time value, unsigned fixed point with 16 fraction bits.
    localparam int unsigned TIME_W = 32;
    // Signed working width for sums, wrap and reflection results.
    localparam int unsigned EXT_W = TIME_W + 4;
    localparam int unsigned CMD_W = 2;
    localparam int unsigned MODE_W = 3;
    localparam int unsigned CFG_IDX_W = 2;

    // Commands.
    localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SEEK = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PLAY = 2'd2;

    // Play modes.
    localparam logic [MODE_W-1:0] MODE_ONCE     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_LOOP     = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PINGPONG = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ONCE_REV = 3'd3;
    localparam logic [MODE_W-1:0] MODE_LOOP_REV = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_START_TIME = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_TIME  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PLAY_MODE  = 2'd2;

    // One command item.
    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic signed [TIME_W-1:0] delta_time;
        logic [TIME_W-1:0]        seek_time;
        logic                     play_flag;
    } pts_in_t;

    // One result item.
    typedef struct packed {
        logic [TIME_W-1:0] current_time;
        logic              playing;
        logic              backward;
    } pts_out_t;

endpackage

`default_nettype wire

// ===== design/playback_time_sequencer_unit.sv =====
// Top level of the playback time sequencer: input slice, step logic, result slice.
//
//  Channel  Ports                         Direction  Carries
//  s_       s_valid s_ready s_data        in         command item (pts_in_t)
//  m_       m_valid m_ready m_data        out        result item (pts_out_t)
//  cfg_     cfg_valid cfg_ready cfg_index cfg_data in  register write
//
// Each item is registered in the input slice, then in the result slice, and
// one item is accepted every cycle unless m_ stalls: the position update is a
// single add, compare and select between the input slice and the result slice.
// Reset (aresetn low, synchronous) clears range, mode, position and flags.
// A stall on m_ holds the result slice and then the input slice; the playback
// state only moves when an item passes into the result slice or, for the
// direction, on a play mode write. Configuration writes are always taken.
`default_nettype none

module playback_time_sequencer_unit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire pts_pkg::pts_in_t              s_data,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output pts_pkg::pts_out_t                  m_data,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [pts_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [pts_pkg::TIME_W-1:0]    cfg_data
);

    import pts_pkg::*;

    logic     item_valid;
    logic     item_ready;
    pts_in_t  item;
    logic     fire;
    pts_out_t result;

    assign cfg_ready = 1'b1;

    // Input slice.
    pts_stage #(
        .WIDTH($bits(pts_in_t))
    ) u_in_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .out_valid (item_valid),
        .out_ready (item_ready),
        .out_data  (item)
    );

    // The item is processed as it moves into the result slice.
    assign fire = item_valid && item_ready;

    pts_step u_step (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_fire  (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fire      (fire),
        .item      (item),
        .result    (result)
    );

    // Result slice.
    pts_stage #(
        .WIDTH($bits(pts_out_t))
    ) u_out_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (item_valid),
        .in_ready  (item_ready),
        .in_data   (result),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

endmodule

`default_nettype wire

// ===== design/pts_stage.sv =====
// Full-throughput register slice with valid and ready on both sides.
`default_nettype none

module pts_stage #(
    parameter int unsigned WIDTH = 1
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [WIDTH-1:0] in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [WIDTH-1:0]      out_data
);

    logic             valid_reg;
    logic             valid_next;
    logic [WIDTH-1:0] data_reg;

    // The slice takes a new transfer when empty or when its content leaves.
    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        valid_next = valid_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload, loaded on every accepted transfer.
    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            data_reg <= in_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

`ifndef NO_ASSERTIONS
    // A held item that is not taken must still be there next cycle.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && !out_ready |=> valid_reg && $stable(data_reg))
        else $error("pts_stage: held item lost");
    // An accepted transfer always leaves the slice occupied.
    a_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid && in_ready |=> valid_reg)
        else $error("pts_stage: accepted transfer not stored");
    // An empty slice that sees no input stays empty.
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !valid_reg && !in_valid |=> !valid_reg)
        else $error("pts_stage: item appeared from nowhere");
`endif

endmodule

`default_nettype wire

// ===== design/pts_step.sv =====
// Playback state, configuration registers and the combinational step logic.
`default_nettype none

module pts_step (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    // Configuration write
    input  wire logic                      cfg_fire,
    input  wire logic [pts_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [pts_pkg::TIME_W-1:0]    cfg_data,
    // Item being processed this cycle
    input  wire logic                      fire,
    input  wire pts_pkg::pts_in_t          item,
    output pts_pkg::pts_out_t              result
);

    import pts_pkg::*;

    logic [TIME_W-1:0] start_reg;
    logic [TIME_W-1:0] stop_reg;
    logic [MODE_W-1:0] mode_reg;
    logic [TIME_W-1:0] pos_reg;
    logic [TIME_W-1:0] pos_next;
    logic              running_reg;
    logic              running_next;
    logic              reverse_reg;
    logic              reverse_next;

    logic [TIME_W-1:0]       hi_u;
    logic signed [EXT_W-1:0] lo_s;
    logic signed [EXT_W-1:0] hi_s;
    logic signed [EXT_W-1:0] pos_s;
    logic signed [EXT_W-1:0] delta_s;
    logic signed [EXT_W-1:0] sum_s;
    logic signed [EXT_W-1:0] bound_s;
    logic signed [EXT_W-1:0] tick_s;
    logic signed [EXT_W-1:0] seek_s;
    logic signed [EXT_W-1:0] tick_clamped;
    logic signed [EXT_W-1:0] seek_clamped;
    logic                    tick_running;
    logic                    tick_reverse;

    // Effective range: the stop bound never lies below start.
    assign hi_u    = (stop_reg > start_reg) ? stop_reg : start_reg;
    assign lo_s    = signed'({{(EXT_W-TIME_W){1'b0}}, start_reg});
    assign hi_s    = signed'({{(EXT_W-TIME_W){1'b0}}, hi_u});
    assign pos_s   = signed'({{(EXT_W-TIME_W){1'b0}}, pos_reg});
    assign delta_s = {{(EXT_W-TIME_W){item.delta_time[TIME_W-1]}}, item.delta_time};
    assign seek_s  = signed'({{(EXT_W-TIME_W){1'b0}}, item.seek_time});

    // Advance in the current direction.
    assign sum_s = reverse_reg ? (pos_s - delta_s) : (pos_s + delta_s);

    // Bound rule of the play mode for a crossed bound.
    always_comb begin
        bound_s      = sum_s;
        tick_running = running_reg;
        tick_reverse = reverse_reg;
        priority if (sum_s < lo_s) begin
            unique case (mode_reg)
                MODE_ONCE_REV: begin
                    bound_s      = lo_s;
                    tick_running = 1'b0;
                end
                MODE_LOOP_REV: begin
                    bound_s = hi_s - lo_s + sum_s;
                end
                MODE_PINGPONG: begin
                    bound_s      = (lo_s <<< 1) - sum_s;
                    tick_reverse = !reverse_reg;
                end
                default: begin
                    bound_s = sum_s;
                end
            endcase
        end else if (sum_s > hi_s) begin
            unique case (mode_reg)
                MODE_ONCE: begin
                    bound_s      = hi_s;
                    tick_running = 1'b0;
                end
                MODE_LOOP: begin
                    bound_s = lo_s + sum_s - hi_s;
                end
                MODE_PINGPONG: begin
                    bound_s      = (hi_s <<< 1) - sum_s;
                    tick_reverse = !reverse_reg;
                end
                default: begin
                    bound_s = sum_s;
                end
            endcase
        end else begin
            bound_s = sum_s;
        end
    end

    // Final clamp of a tick and of a seek into the range.
    always_comb begin
        tick_s = bound_s;
        if (bound_s < lo_s) begin
            tick_s = lo_s;
        end else if (bound_s > hi_s) begin
            tick_s = hi_s;
        end
        tick_clamped = tick_s;
        seek_clamped = seek_s;
        if (seek_s < lo_s) begin
            seek_clamped = lo_s;
        end else if (seek_s > hi_s) begin
            seek_clamped = hi_s;
        end
    end

    // Next playback state for the item's command.
    always_comb begin
        pos_next     = pos_reg;
        running_next = running_reg;
        reverse_next = reverse_reg;
        unique case (item.cmd)
            CMD_TICK: begin
                if (running_reg) begin
                    pos_next     = tick_clamped[TIME_W-1:0];
                    running_next = tick_running;
                    reverse_next = tick_reverse;
                end
            end
            CMD_SEEK: begin
                pos_next = seek_clamped[TIME_W-1:0];
            end
            CMD_PLAY: begin
                running_next = item.play_flag;
            end
            default: begin
                pos_next = pos_reg;
            end
        endcase
    end

    assign result.current_time = pos_next;
    assign result.playing      = running_next;
    assign result.backward     = reverse_next;

    // Configuration and playback state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg   <= '0;
            stop_reg    <= '0;
            mode_reg    <= MODE_ONCE;
            pos_reg     <= '0;
            running_reg <= 1'b0;
            reverse_reg <= 1'b0;
        end else begin
            if (cfg_fire) begin
                unique case (cfg_index)
                    REG_START_TIME: start_reg <= cfg_data;
                    REG_STOP_TIME:  stop_reg  <= cfg_data;
                    REG_PLAY_MODE:  mode_reg  <= cfg_data[MODE_W-1:0];
                    default:        mode_reg  <= mode_reg;
                endcase
            end
            if (fire) begin
                pos_reg     <= pos_next;
                running_reg <= running_next;
            end
            priority if (fire) begin
                reverse_reg <= reverse_next;
            end else if (cfg_fire && (cfg_index == REG_PLAY_MODE)) begin
                reverse_reg <= (cfg_data[MODE_W-1:0] == MODE_ONCE_REV) ||
                               (cfg_data[MODE_W-1:0] == MODE_LOOP_REV);
            end
        end
    end

`ifndef NO_ASSERTIONS
    // A seek always leaves the position inside the range it was clamped to.
    a_seek_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && !cfg_fire && (item.cmd == CMD_SEEK) |=>
            (pos_reg >= start_reg) && (pos_reg <= hi_u))
        else $error("pts_step: seek left position out of range");
    // A tick while stopped changes nothing.
    a_tick_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && (item.cmd == CMD_TICK) && !running_reg |=>
            $stable(pos_reg) && !running_reg)
        else $error("pts_step: tick moved a stopped position");
    // Only ping-pong turns the direction around during a tick.
    a_flip_pingpong: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && (item.cmd == CMD_TICK) && (mode_reg != MODE_PINGPONG) |=>
            $stable(reverse_reg))
        else $error("pts_step: direction flipped outside ping-pong");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the playback time sequencer: directed cases, then random traffic.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import pts_pkg::*;

    // Codes the block ignores, used on purpose by the stimulus.
    localparam logic [CMD_W-1:0]     CMD_NOP       = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED    = 2'd3;
    localparam logic [MODE_W-1:0]    MODE_SPARE_LO = 3'd5;
    localparam logic [MODE_W-1:0]    MODE_SPARE_HI = 3'd7;

    // One second in Q16.16.
    localparam logic [TIME_W-1:0] SEC = 32'h0001_0000;
    localparam int CYCLE_LIMIT = 200000;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    pts_in_t              s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    pts_out_t             m_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [TIME_W-1:0]    cfg_data  = '0;

    // Shadow copy of the block's registers and playback state.
    logic [TIME_W-1:0] range_start = '0;
    logic [TIME_W-1:0] range_stop  = '0;
    logic [MODE_W-1:0] mode_q      = '0;
    logic [TIME_W-1:0] pos_q       = '0;
    logic              is_running  = 1'b0;
    logic              is_backward = 1'b0;

    pts_out_t position_reports[$];
    int       fault_count = 0;
    int       cycle_count = 0;
    int       send_idle_pct = 20;
    int       recv_idle_pct = 80;

    playback_time_sequencer_unit DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Apply one command to the shadow state and return the position report it yields.
    function automatic pts_out_t advance_playback(pts_in_t item);
        longint   lo;
        longint   hi;
        longint   p;
        longint   delta;
        pts_out_t res;
        lo = longint'({32'b0, range_start});
        hi = (range_stop > range_start) ? longint'({32'b0, range_stop}) : lo;
        case (item.cmd)
            CMD_TICK: begin
                if (is_running) begin
                    delta = longint'($signed(item.delta_time));
                    p = longint'({32'b0, pos_q}) + (is_backward ? -delta : delta);
                    // Bound rules per mode; unmatched crossings fall through to the clamp.
                    if (p < lo) begin
                        if (mode_q == MODE_ONCE_REV) begin
                            p = lo;
                            is_running = 1'b0;
                        end else if (mode_q == MODE_LOOP_REV) begin
                            p = hi - (lo - p);
                        end else if (mode_q == MODE_PINGPONG) begin
                            p = lo + (lo - p);
                            is_backward = !is_backward;
                        end
                    end else if (p > hi) begin
                        if (mode_q == MODE_ONCE) begin
                            p = hi;
                            is_running = 1'b0;
                        end else if (mode_q == MODE_LOOP) begin
                            p = lo + (p - hi);
                        end else if (mode_q == MODE_PINGPONG) begin
                            p = hi - (p - hi);
                            is_backward = !is_backward;
                        end
                    end
                    if (p < lo) p = lo;
                    else if (p > hi) p = hi;
                    pos_q = p[TIME_W-1:0];
                end
            end
            CMD_SEEK: begin
                p = longint'({32'b0, item.seek_time});
                if (p < lo) p = lo;
                else if (p > hi) p = hi;
                pos_q = p[TIME_W-1:0];
            end
            CMD_PLAY: is_running = item.play_flag;
            default: ;
        endcase
        res.current_time = pos_q;
        res.playing      = is_running;
        res.backward     = is_backward;
        return res;
    endfunction

    // Build a command; the time fields it does not use carry random values.
    function automatic pts_in_t make_item(logic [CMD_W-1:0] cmd, logic [TIME_W-1:0] arg,
                                          logic flag);
        pts_in_t item;
        item.cmd        = cmd;
        item.delta_time = $urandom;
        item.seek_time  = $urandom;
        item.play_flag  = flag;
        if (cmd == CMD_TICK) item.delta_time = arg;
        else if (cmd == CMD_SEEK) item.seek_time = arg;
        return item;
    endfunction

    // Random command, mostly ticks sized to the current range.
    function automatic pts_in_t random_item();
        longint            lo;
        longint            span;
        longint            lim;
        logic [TIME_W-1:0] mag;
        int                pick;
        lo   = longint'({32'b0, range_start});
        span = (range_stop > range_start) ? longint'({32'b0, range_stop}) - lo : 0;
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
            pick = $urandom_range(0, 99);
            if (pick < 15 || span == 0) begin
                mag = $urandom;
            end else begin
                lim = (pick < 70) ? span / 4 + 1 : span * 2 + 1;
                if (lim > 64'h7FFF_FFFF) lim = 64'h7FFF_FFFF;
                mag = $urandom_range(0, lim[31:0]);
                if ($urandom_range(0, 3) == 0) mag = -mag;
            end
            return make_item(CMD_TICK, mag, 1'($urandom_range(0, 1)));
        end else if (pick < 78) begin
            if ($urandom_range(0, 1) == 0 && span != 0)
                mag = range_start + $urandom_range(0, span[31:0]);
            else
                mag = $urandom;
            return make_item(CMD_SEEK, mag, 1'($urandom_range(0, 1)));
        end else if (pick < 93) begin
            return make_item(CMD_PLAY, $urandom, $urandom_range(0, 99) < 85);
        end
        return make_item(CMD_NOP, $urandom, 1'($urandom_range(0, 1)));
    endfunction

    // Present one command, wait for its transfer and record its prediction.
    // Called and returns just after a falling edge; valid stays up for a following item.
    task automatic send_item(input pts_in_t item);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_data  <= item;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        position_reports.push_back(advance_playback(item));
        @(negedge aclk);
    endtask

    // Stop sending and wait until every predicted report has come back.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (position_reports.size() != 0) @(negedge aclk);
    endtask

    // Register write, only once the block has gone quiet.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [TIME_W-1:0] value);
        drain_results();
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_START_TIME: range_start = value;
            REG_STOP_TIME:  range_stop  = value;
            REG_PLAY_MODE: begin
                mode_q      = value[MODE_W-1:0];
                is_backward = (mode_q == MODE_ONCE_REV) || (mode_q == MODE_LOOP_REV);
            end
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic write_mode(input logic [MODE_W-1:0] mode);
        logic [TIME_W-1:0] value;
        value = $urandom;
        value[MODE_W-1:0] = mode;
        write_register(REG_PLAY_MODE, value);
    endtask

    // Fresh out of reset: a stopped tick, a seek into a zero-width range, an ignored command.
    task automatic test_power_up();
        send_item(make_item(CMD_TICK, SEC, 1'b1));
        send_item(make_item(CMD_SEEK, 32'hFFFF_FFFF, 1'b0));
        send_item(make_item(CMD_NOP, $urandom, 1'b1));
    endtask

    // Once modes: stop at the end, clamp only at the other bound.
    task automatic test_once_modes();
        write_register(REG_START_TIME, SEC);
        write_register(REG_STOP_TIME, 4 * SEC);
        write_mode(MODE_ONCE);
        send_item(make_item(CMD_SEEK, 32'h0, 1'b0));
        send_item(make_item(CMD_PLAY, 32'h0, 1'b1));
        send_item(make_item(CMD_TICK, SEC / 2, 1'b0));
        send_item(make_item(CMD_TICK, 32'h7FFF_FFFF, 1'b0));
        send_item(make_item(CMD_TICK, SEC, 1'b0));
        send_item(make_item(CMD_PLAY, 32'h0, 1'b1));
        send_item(make_item(CMD_TICK, 32'h8000_0000, 1'b0));
        write_mode(MODE_ONCE_REV);
        send_item(make_item(CMD_SEEK, 3 * SEC, 1'b0));
        send_item(make_item(CMD_TICK, SEC, 1'b0));
        send_item(make_item(CMD_TICK, 4 * SEC, 1'b0));
    endtask

    // Wrap, reflection, reverse loop and the modes with no bound rule.
    task automatic test_wrap_and_reflect();
        write_mode(MODE_LOOP);
        send_item(make_item(CMD_PLAY, 32'h0, 1'b1));
        send_item(make_item(CMD_SEEK, 3 * SEC + SEC / 2, 1'b0));
        send_item(make_item(CMD_TICK, SEC, 1'b0));
        // A wrap that still lands outside the range gets clamped.
        send_item(make_item(CMD_TICK, 32'h7FFF_FFFF, 1'b0));
        write_mode(MODE_PINGPONG);
        send_item(make_item(CMD_SEEK, 3 * SEC + SEC / 2, 1'b0));
        send_item(make_item(CMD_TICK, SEC, 1'b0));
        send_item(make_item(CMD_TICK, 3 * SEC, 1'b0));
        write_mode(MODE_LOOP_REV);
        send_item(make_item(CMD_TICK, SEC, 1'b0));
        send_item(make_item(CMD_TICK, -SEC, 1'b0));
        write_register(REG_PLAY_MODE, 32'hFFFF_FFF8 | MODE_SPARE_LO);
        send_item(make_item(CMD_TICK, 32'h8000_0000, 1'b0));
        write_register(REG_UNUSED, $urandom);
        write_mode(MODE_SPARE_HI);
        send_item(make_item(CMD_NOP, $urandom, 1'b0));
    endtask

    // Stop below start, a position left outside a new range, full-scale ranges.
    task automatic test_range_edges();
        write_register(REG_START_TIME, 32'hFFFF_0000);
        write_register(REG_STOP_TIME, 32'h0000_1000);
        send_item(make_item(CMD_NOP, $urandom, 1'b1));
        send_item(make_item(CMD_SEEK, 32'h0, 1'b1));
        write_register(REG_START_TIME, 32'h0);
        write_register(REG_STOP_TIME, 32'hFFFF_FFFF);
        write_mode(MODE_LOOP);
        send_item(make_item(CMD_PLAY, 32'h0, 1'b1));
        send_item(make_item(CMD_SEEK, 32'hFFFF_FFFF, 1'b0));
        send_item(make_item(CMD_TICK, 32'h7FFF_FFFF, 1'b0));
        write_register(REG_START_TIME, 32'hFFFF_FFFF);
        send_item(make_item(CMD_TICK, SEC, 1'b0));
    endtask

    // Random ranges and modes, each followed by a run of mostly well-formed playback.
    task automatic test_random_playback();
        logic [TIME_W-1:0] first;
        logic [TIME_W-1:0] second;
        for (int idle = 0; idle < 3; idle++) begin
            send_idle_pct = (idle == 0) ? 20 : (idle == 1) ? 80 : 0;
            recv_idle_pct = (idle == 0) ? 80 : (idle == 1) ? 20 : 0;
            for (int phase = 0; phase < 6; phase++) begin
                case ($urandom_range(0, 5))
                    0: begin
                        first  = $urandom_range(0, 32'hFFFF);
                        second = first + $urandom_range(32'h100, 32'h4_0000);
                    end
                    1: begin
                        first  = 32'h0;
                        second = 32'hFFFF_FFFF;
                    end
                    2: begin
                        first  = 32'hFFFF_FFFF - $urandom_range(0, 32'h8_0000);
                        second = 32'hFFFF_FFFF;
                    end
                    3: begin
                        first  = $urandom | 32'h8000_0000;
                        second = first >> 1;
                    end
                    4: begin
                        first  = $urandom;
                        second = first;
                    end
                    default: begin
                        first  = $urandom;
                        second = $urandom;
                    end
                endcase
                write_register(REG_START_TIME, first);
                write_register(REG_STOP_TIME, second);
                if ($urandom_range(0, 7) == 0)
                    write_mode(MODE_W'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI)));
                else write_mode(MODE_W'($urandom_range(MODE_ONCE, MODE_LOOP_REV)));
                if ($urandom_range(0, 3) == 0) write_register(REG_UNUSED, $urandom);
                send_item(make_item(CMD_PLAY, $urandom, 1'b1));
                repeat (35) send_item(random_item());
            end
        end
    endtask

    // Receiver back-pressure.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // Compare each result transfer with the oldest prediction.
    always @(posedge aclk) begin
        pts_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (position_reports.size() == 0) begin
                $error("result transfer with nothing predicted: current_time %h",
                       m_data.current_time);
                fault_count++;
            end else begin
                want = position_reports.pop_front();
                if (m_data.current_time !== want.current_time) begin
                    $error("current_time: expected %h, got %h",
                           want.current_time, m_data.current_time);
                    fault_count++;
                end
                if (m_data.playing !== want.playing) begin
                    $error("playing: expected %b, got %b", want.playing, m_data.playing);
                    fault_count++;
                end
                if (m_data.backward !== want.backward) begin
                    $error("backward: expected %b, got %b", want.backward, m_data.backward);
                    fault_count++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("** playback_time_sequencer_unit: FAILED **");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_power_up();
        test_once_modes();
        test_wrap_and_reflect();
        test_range_edges();
        test_random_playback();
        drain_results();
        repeat (8) @(posedge aclk);
        if (fault_count == 0 && position_reports.size() == 0) begin
            $display("** playback_time_sequencer_unit: PASSED **");
        end else begin
            $display("** playback_time_sequencer_unit: FAILED **");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/pts_pkg.sv
design/pts_stage.sv
design/pts_step.sv
design/playback_time_sequencer_unit.sv
tb/tb_top.sv
